### hdl/dltq_pkg.sv
// Shared types and constants for the delta list timer queue.
`timescale 1ns / 1ps
`default_nettype none
package dltq_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int MaxResults        = 16;
  localparam int MaxResultsW       = $clog2(MaxResults + 1);
  localparam int DeltaW            = 32;
  localparam int TagW              = 16;

  typedef enum logic {
    OpTick   = 1'b0,
    OpCreate = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KindAccepted = 2'd0,
    KindRefused  = 2'd1,
    KindExpired  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StTickDec,
    StPop
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [DeltaW-1:0] delay_ticks;
    logic [TagW-1:0]   tag;
  } in_t;

  typedef struct packed {
    kind_e           kind;
    logic [TagW-1:0] expired_tag;
    logic            last;
  } out_t;

  typedef struct packed {
    logic [DeltaW-1:0] delta;
    logic [TagW-1:0]   tag;
  } entry_t;

  // Per-cell control: shift takes the neighbor's entry, dec decrements in place.
  typedef struct packed {
    logic shift;
    logic dec;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### hdl/dltq_cell.sv
// One queue cell: holds one entry, shifts toward the head, decrements in place.
`timescale 1ns / 1ps
`default_nettype none
module dltq_cell (
  input  wire                       clk_i,
  input  wire dltq_pkg::cell_ctrl_t ctrl_i,
  input  wire dltq_pkg::entry_t     entry_i,
  output dltq_pkg::entry_t          entry_o,
  output logic                      zero_o
);

  dltq_pkg::entry_t entry_q, entry_d;

  assign zero_o  = (entry_q.delta == '0);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = entry_i;
    end else if (ctrl_i.dec && !zero_o) begin
      entry_d.delta = entry_q.delta - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

### hdl/delta_list_timer_queue.sv
// Top level of the delta list timer queue: cell chain plus scan and pop control.
//
//   channel  | ports                        | handshake
//   ---------+------------------------------+-----------------------------------
//   command  | start_i, busy_o, in_i        | word taken when start_i && !busy_o
//   result   | result_strobe_o, result_o    | word valid for one cycle, no stall
//
// A create rotates the whole cell chain once through the head, where one
// subtractor finds the insertion point and a hold register opens the gap.
// A refused create answers the cycle after it is taken.
// A tick decrements the head in StTickDec, then pops each expired entry
// in StPop, at most MaxResults per tick; an empty queue ignores a tick.
// Reset clears the entry count and control; cell contents stay undefined.
// Results cannot be stalled; the next word is taken while one is shown.
`timescale 1ns / 1ps
`default_nettype none
module delta_list_timer_queue #(
  parameter int QUEUE_DEPTH = dltq_pkg::QueueDepthDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  wire dltq_pkg::in_t  in_i,
  output logic                result_strobe_o,
  output dltq_pkg::out_t      result_o
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam int NW   = dltq_pkg::MaxResultsW;

  dltq_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  step_q, step_d;
  logic [NW-1:0]    npop_q, npop_d;
  logic             search_q, search_d;
  logic [dltq_pkg::DeltaW-1:0] rem_q, rem_d;
  logic [dltq_pkg::TagW-1:0]   new_tag_q, new_tag_d;
  dltq_pkg::entry_t hold_q, hold_d;
  logic             strobe_q, strobe_d;
  dltq_pkg::out_t   result_q, result_d;

  dltq_pkg::cell_ctrl_t cell_ctrl [QUEUE_DEPTH];
  dltq_pkg::entry_t     cell_in   [QUEUE_DEPTH];
  dltq_pkg::entry_t     cell_out  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_zero;

  logic             shift_all;
  logic             dec_head;
  dltq_pkg::entry_t tail_in;
  logic             accept;
  logic             head_valid;
  logic             last_step;
  logic [dltq_pkg::DeltaW:0] diff;
  logic             pop_now;
  logic             more_pops;

  // The chain shifts toward the head; the tail is fed by the head logic.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign cell_in[i] = tail_in;
    end else begin : g_body
      assign cell_in[i] = cell_out[i+1];
    end
    assign cell_ctrl[i].shift = shift_all;
    assign cell_ctrl[i].dec   = (i == 0) ? dec_head : 1'b0;

    dltq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .entry_i (cell_in[i]),
      .entry_o (cell_out[i]),
      .zero_o  (cell_zero[i])
    );
  end

  assign busy_o     = (state_q != dltq_pkg::StIdle);
  assign accept     = start_i && !busy_o;
  assign head_valid = (CntW'(step_q) < count_q);
  assign last_step  = (step_q == IdxW'(QUEUE_DEPTH - 1));
  // A borrow out of the difference means the remainder is below the head delta.
  assign diff       = {1'b0, rem_q} - {1'b0, cell_out[0].delta};
  assign pop_now    = (count_q != '0) && cell_zero[0] && (npop_q < NW'(dltq_pkg::MaxResults));
  assign more_pops  = (count_q > CntW'(1)) && cell_zero[1]
                      && (npop_q < NW'(dltq_pkg::MaxResults - 1));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    step_d    = step_q;
    npop_d    = npop_q;
    search_d  = search_q;
    rem_d     = rem_q;
    new_tag_d = new_tag_q;
    hold_d    = hold_q;
    strobe_d  = 1'b0;
    result_d  = result_q;
    shift_all = 1'b0;
    dec_head  = 1'b0;
    tail_in   = cell_out[0];

    unique case (state_q)
      dltq_pkg::StIdle: begin
        if (accept) begin
          rem_d     = in_i.delay_ticks;
          new_tag_d = in_i.tag;
          step_d    = '0;
          npop_d    = '0;
          search_d  = 1'b1;
          if (in_i.op == dltq_pkg::OpCreate) begin
            if (count_q == CntW'(QUEUE_DEPTH)) begin
              strobe_d             = 1'b1;
              result_d.kind        = dltq_pkg::KindRefused;
              result_d.expired_tag = in_i.tag;
              result_d.last        = 1'b1;
            end else begin
              state_d = dltq_pkg::StScan;
            end
          end else if (count_q != '0) begin
            state_d = dltq_pkg::StTickDec;
          end
        end
      end

      dltq_pkg::StScan: begin
        shift_all = 1'b1;
        if (search_q) begin
          if (!head_valid || (rem_q == '0) || diff[dltq_pkg::DeltaW]) begin
            tail_in.delta = rem_q;
            tail_in.tag   = new_tag_q;
            hold_d.delta  = '0 - diff[dltq_pkg::DeltaW-1:0];
            hold_d.tag    = cell_out[0].tag;
            search_d      = 1'b0;
          end else begin
            tail_in = cell_out[0];
            rem_d   = diff[dltq_pkg::DeltaW-1:0];
          end
        end else begin
          tail_in = hold_q;
          hold_d  = cell_out[0];
        end
        step_d = step_q + 1'b1;
        if (last_step) begin
          count_d              = count_q + 1'b1;
          strobe_d             = 1'b1;
          result_d.kind        = dltq_pkg::KindAccepted;
          result_d.expired_tag = new_tag_q;
          result_d.last        = 1'b1;
          state_d              = dltq_pkg::StIdle;
        end
      end

      dltq_pkg::StTickDec: begin
        dec_head = 1'b1;
        state_d  = dltq_pkg::StPop;
      end

      dltq_pkg::StPop: begin
        if (pop_now) begin
          shift_all            = 1'b1;
          count_d              = count_q - 1'b1;
          npop_d               = npop_q + 1'b1;
          strobe_d             = 1'b1;
          result_d.kind        = dltq_pkg::KindExpired;
          result_d.expired_tag = cell_out[0].tag;
          result_d.last        = !more_pops;
          if (!more_pops) begin
            state_d = dltq_pkg::StIdle;
          end
        end else begin
          state_d = dltq_pkg::StIdle;
        end
      end

      default: begin
        state_d = dltq_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dltq_pkg::StIdle;
      count_q  <= '0;
      step_q   <= '0;
      npop_q   <= '0;
      search_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      step_q   <= step_d;
      npop_q   <= npop_d;
      search_q <= search_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    new_tag_q <= new_tag_d;
    hold_q    <= hold_d;
    result_q  <= result_d;
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_accept_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && result_q.kind == dltq_pkg::KindAccepted) |->
      count_q == $past(count_q) + 1'b1)
    else $error("accepted create did not add an entry");

  a_expire_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && result_q.kind == dltq_pkg::KindExpired) |->
      count_q == $past(count_q) - 1'b1)
    else $error("expiry did not remove an entry");

  a_refuse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && result_q.kind == dltq_pkg::KindRefused) |->
      count_q == CntW'(QUEUE_DEPTH))
    else $error("create refused with room in the queue");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && result_q.last) |-> !busy_o)
    else $error("still busy after the final result");
`endif

endmodule
`default_nettype wire

### dv/tb_delta_list_timer_queue.sv
// Self-checking testbench for the delta list timer queue: directed and random commands.
`timescale 1ns / 1ps
module tb_delta_list_timer_queue;

  localparam int QueueDepth    = dltq_pkg::QueueDepthDefault;
  localparam int WatchdogLimit = 3000;
  localparam int RandomWords   = 243;

  // Tracks the timer list and the result words it should produce.
  class timer_scoreboard;
    int unsigned        depth;
    int unsigned        errors;
    dltq_pkg::entry_t   timers[$];
    dltq_pkg::out_t     expected_q[$];

    function new(int unsigned queue_depth);
      depth  = queue_depth;
      errors = 0;
    endfunction

    task report(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task note_command(input dltq_pkg::in_t w);
      dltq_pkg::entry_t            e;
      dltq_pkg::out_t              r;
      int unsigned                 pos;
      int unsigned                 n;
      logic [dltq_pkg::DeltaW-1:0] rem;
      if (w.op == dltq_pkg::OpCreate) begin
        r.expired_tag = w.tag;
        r.last        = 1'b1;
        if (timers.size() >= depth) begin
          r.kind = dltq_pkg::KindRefused;
        end else begin
          // Walk the deltas until the remainder runs out or fits ahead of an entry.
          rem = w.delay_ticks;
          pos = 0;
          while (pos < timers.size() && rem != 0 && rem >= timers[pos].delta) begin
            rem = rem - timers[pos].delta;
            pos++;
          end
          if (pos < timers.size()) timers[pos].delta = timers[pos].delta - rem;
          e.delta = rem;
          e.tag   = w.tag;
          timers.insert(pos, e);
          r.kind = dltq_pkg::KindAccepted;
        end
        expected_q.push_back(r);
      end else if (timers.size() > 0) begin
        // A head that is already zero is not decremented again.
        if (timers[0].delta != 0) timers[0].delta = timers[0].delta - 1;
        n = 0;
        while (timers.size() > 0 && timers[0].delta == 0 && n < dltq_pkg::MaxResults) begin
          r.kind        = dltq_pkg::KindExpired;
          r.expired_tag = timers[0].tag;
          r.last        = 1'b0;
          expected_q.push_back(r);
          void'(timers.pop_front());
          n++;
        end
        if (n > 0) expected_q[expected_q.size() - 1].last = 1'b1;
      end
    endtask

    task check_result(input dltq_pkg::out_t got);
      dltq_pkg::out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result word with nothing expected: kind %0d tag %h last %b",
                         got.kind, got.expired_tag, got.last));
      end else begin
        want = expected_q.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.expired_tag !== want.expired_tag)
          report($sformatf("expired_tag %h, expected %h", got.expired_tag, want.expired_tag));
        if (got.last !== want.last)
          report($sformatf("last %b, expected %b (tag %h)", got.last, want.last,
                           want.expired_tag));
      end
    endtask
  endclass

  logic           clk_i   = 1'b0;
  logic           rst_ni  = 1'b0;
  logic           start_i = 1'b0;
  logic           busy_o;
  dltq_pkg::in_t  in_i    = '0;
  logic           result_strobe_o;
  dltq_pkg::out_t result_o;

  timer_scoreboard sb;
  int unsigned     stall_cycles = 0;
  int unsigned     create_pct   = 50;
  int unsigned     big_left     = 3;

  delta_list_timer_queue #(
    .QUEUE_DEPTH(QueueDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_i           (in_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic dltq_pkg::in_t make_word(input dltq_pkg::op_e op,
                                              input logic [dltq_pkg::DeltaW-1:0] delay,
                                              input logic [dltq_pkg::TagW-1:0] tag);
    dltq_pkg::in_t w;
    w.op          = op;
    w.delay_ticks = delay;
    w.tag         = tag;
    return w;
  endfunction

  // Mostly short delays so the list keeps turning over; a few huge ones stay queued.
  function automatic dltq_pkg::in_t random_word();
    dltq_pkg::in_t w;
    int unsigned   roll;
    w.op          = dltq_pkg::OpTick;
    w.delay_ticks = $urandom;
    w.tag         = 16'($urandom);
    if ($urandom_range(99) < create_pct) begin
      w.op = dltq_pkg::OpCreate;
      roll = $urandom_range(99);
      if (roll < 15) w.delay_ticks = '0;
      else if (roll < 80) w.delay_ticks = $urandom_range(8, 1);
      else if (roll < 97 || big_left == 0) w.delay_ticks = $urandom_range(40, 9);
      else big_left--;
    end
    return w;
  endfunction

  task automatic send_word(input dltq_pkg::in_t w, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_command(in_i);
      if (result_strobe_o) sb.check_result(result_o);
      if ((start_i && !busy_o) || result_strobe_o) begin
        stall_cycles = 0;
      end else if (stall_cycles == WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        stall_cycles++;
      end
    end
  end

  initial begin
    int unsigned idle_pct;
    sb = new(QueueDepth);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tick on an empty list, then a zero-delay head that must expire without wrapping.
    send_word(make_word(dltq_pkg::OpTick, 32'hFFFF_FFFF, 16'hFFFF), 11);
    send_word(make_word(dltq_pkg::OpCreate, 32'd0, 16'hFFFF), 11);
    send_word(make_word(dltq_pkg::OpCreate, 32'd2, 16'h0001), 11);
    send_word(make_word(dltq_pkg::OpCreate, 32'd2, 16'h0002), 11);
    send_word(make_word(dltq_pkg::OpTick, 32'd0, 16'h0000), 11);
    send_word(make_word(dltq_pkg::OpTick, 32'd0, 16'h0000), 11);
    // Two entries expire together and the list runs empty.
    send_word(make_word(dltq_pkg::OpTick, 32'd0, 16'h0000), 11);

    // Fill the list, one entry with the largest delay, then a refused create.
    for (int i = 0; i < QueueDepth; i++)
      send_word(make_word(dltq_pkg::OpCreate, (i == 5) ? 32'hFFFF_FFFF : 32'd3,
                          16'(16'h1000 + i)), 11);
    send_word(make_word(dltq_pkg::OpCreate, 32'd0, 16'h5A5A), 11);
    // The third tick drains every entry but the largest one in a single burst.
    repeat (3) send_word(make_word(dltq_pkg::OpTick, 32'd0, 16'h0000), 11);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 11 : (phase == 1) ? 85 : 0;
      for (int i = 0; i < RandomWords / 3; i++) begin
        if (i % 30 == 0) create_pct = $urandom_range(75, 25);
        send_word(random_word(), idle_pct);
      end
    end
    start_i <= 1'b0;

    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4 * QueueDepth) @(posedge clk_i);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
